// ===== rtl/core/iau_pkg.sv =====
// shared types, codes and saturation helper for the interval arithmetic unit
`timescale 1ns / 1ps

package iau_pkg;

    typedef enum logic [2:0] {
        MODE_ADD_B = 3'd0,
        MODE_ADD_S = 3'd1,
        MODE_SUB_B = 3'd2,
        MODE_SUB_S = 3'd3,
        MODE_MUL_B = 3'd4,
        MODE_MUL_S = 3'd5,
        MODE_DIV_S = 3'd6,
        MODE_LEN   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } sat_t;

    // clamp a wide signed value to 32 bits
    function automatic sat_t sat32(input logic signed [65:0] x);
        sat_t r;
        if (x[65:31] != {35{x[65]}})
        begin
            r.ovf = 1'b1;
            r.val = x[65] ? S32_MIN : S32_MAX;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/interval_arithmetic_unit.sv =====
// interval alu top level: operand prep, product unit, divider lanes, result select
// throughput: one request per cycle while the pipe is not stalled; the divider lanes retire one quotient bit per stage
// the whole pipe advances unless the output register holds a result that is stalled
// reset clears all valid bits and sets tolerance to 1; payload registers are not reset
`timescale 1ns / 1ps

module interval_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         mode,
    input  logic signed [31:0] a_min,
    input  logic signed [31:0] a_max,
    input  logic signed [31:0] b_min,
    input  logic signed [31:0] b_max,
    input  logic signed [31:0] scalar,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] r_min,
    output logic signed [31:0] r_max,
    output logic               holds_zero,
    output logic               differs,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data
);

    localparam int QW = 32 + FRAC_BITS;

    typedef struct packed {
        iau_pkg::mode_t     mode;
        logic signed [31:0] res_lo;
        logic signed [31:0] res_hi;
        logic               res_ovf;
        logic               holds_zero;
        logic               differs;
        logic               neg_lo;
        logic               neg_hi;
        logic               div0;
        logic               lo_pos;
        logic               lo_neg;
        logic               hi_pos;
        logic               hi_neg;
    } side_t;

    logic               adv;
    logic [30:0]        tolerance_reg;

    // valid bits
    logic               v0_reg, v1_reg, v2_reg, v3_reg, vf_reg, out_valid_reg;
    logic [QW-1:0]      vd_reg;

    // stage 0: input register
    iau_pkg::mode_t     r0_mode;
    logic signed [31:0] r0_a_min, r0_a_max, r0_b_min, r0_b_max, r0_s;

    // stage 1
    iau_pkg::mode_t     r1_mode;
    logic signed [31:0] r1_als_lo, r1_als_hi;
    logic               r1_als_ovf, r1_hz;
    logic signed [32:0] r1_d_lo, r1_d_hi;
    logic [31:0]        r1_mag_lo, r1_mag_hi, r1_den;
    logic               r1_neg_lo, r1_neg_hi, r1_div0;
    logic               r1_lo_pos, r1_lo_neg, r1_hi_pos, r1_hi_neg;

    // stage 2 and 3
    iau_pkg::mode_t     r2_mode, r3_mode;
    logic signed [31:0] r2_als_lo, r2_als_hi, r3_als_lo, r3_als_hi;
    logic               r2_als_ovf, r3_als_ovf, r2_hz, r3_hz, r2_diff, r3_diff;
    logic [31:0]        r2_mag_lo, r2_mag_hi, r2_den, r3_mag_lo, r3_mag_hi, r3_den;
    logic               r2_neg_lo, r2_neg_hi, r2_div0, r3_neg_lo, r3_neg_hi, r3_div0;
    logic               r2_lo_pos, r2_lo_neg, r2_hi_pos, r2_hi_neg;
    logic               r3_lo_pos, r3_lo_neg, r3_hi_pos, r3_hi_neg;

    side_t              side_reg [QW];
    side_t              side_next;

    // fix stage
    side_t              f_side;
    logic signed [31:0] fq_lo, fq_hi;
    logic               fq_ovf;

    // output register
    logic signed [31:0] r_min_reg, r_max_reg, r_min_next, r_max_next;
    logic               hz_reg, diff_reg;
    iau_pkg::status_t   status_reg, status_next;

    // combinational helpers
    logic signed [33:0] als_lo_w, als_hi_w;
    iau_pkg::sat_t      als_lo_s, als_hi_s;
    logic signed [33:0] tol_x, d_lo_x, d_hi_x;
    logic signed [31:0] mb0, mb1;
    logic signed [31:0] mul_lo, mul_hi;
    logic               mul_ovf;
    logic [QW-1:0]      quo_lo, quo_hi;
    logic signed [QW:0] q_lo_w, q_hi_w;
    iau_pkg::sat_t      q_lo_s, q_hi_s;
    logic signed [31:0] dl, dh;

    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // stage 1 arithmetic
    always_comb
    begin
        case (r0_mode)
            iau_pkg::MODE_ADD_B:
            begin
                als_lo_w = 34'(r0_a_min) + 34'(r0_b_min);
                als_hi_w = 34'(r0_a_max) + 34'(r0_b_max);
            end
            iau_pkg::MODE_ADD_S:
            begin
                als_lo_w = 34'(r0_a_min) + 34'(r0_s);
                als_hi_w = 34'(r0_a_max) + 34'(r0_s);
            end
            iau_pkg::MODE_SUB_B:
            begin
                als_lo_w = 34'(r0_a_min) - 34'(r0_b_max);
                als_hi_w = 34'(r0_a_max) - 34'(r0_b_min);
            end
            iau_pkg::MODE_SUB_S:
            begin
                als_lo_w = 34'(r0_a_min) - 34'(r0_s);
                als_hi_w = 34'(r0_a_max) - 34'(r0_s);
            end
            iau_pkg::MODE_LEN:
            begin
                als_lo_w = 34'(r0_a_max) - 34'(r0_a_min);
                als_hi_w = als_lo_w;
            end
            default:
            begin
                als_lo_w = '0;
                als_hi_w = '0;
            end
        endcase
        als_lo_s = iau_pkg::sat32(66'(als_lo_w));
        als_hi_s = iau_pkg::sat32(66'(als_hi_w));
        mb0      = (r0_mode == iau_pkg::MODE_MUL_S) ? r0_s : r0_b_min;
        mb1      = (r0_mode == iau_pkg::MODE_MUL_S) ? r0_s : r0_b_max;
    end

    // stage 2 tolerance compare, both signs against the same bound
    always_comb
    begin
        tol_x  = 34'(tolerance_reg);
        d_lo_x = 34'(r1_d_lo);
        d_hi_x = 34'(r1_d_hi);
    end

    iau_mul_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .en    (adv),
        .a_min (r0_a_min),
        .a_max (r0_a_max),
        .b0    (mb0),
        .b1    (mb1),
        .scal  (r0_mode == iau_pkg::MODE_MUL_S),
        .swap  (r0_s[31]),
        .lo    (mul_lo),
        .hi    (mul_hi),
        .ovf   (mul_ovf)
    );

    always_comb
    begin
        side_next.mode       = r3_mode;
        if (r3_mode == iau_pkg::MODE_MUL_B || r3_mode == iau_pkg::MODE_MUL_S)
        begin
            side_next.res_lo  = mul_lo;
            side_next.res_hi  = mul_hi;
            side_next.res_ovf = mul_ovf;
        end
        else
        begin
            side_next.res_lo  = r3_als_lo;
            side_next.res_hi  = r3_als_hi;
            side_next.res_ovf = r3_als_ovf;
        end
        side_next.holds_zero = r3_hz;
        side_next.differs    = r3_diff;
        side_next.neg_lo     = r3_neg_lo;
        side_next.neg_hi     = r3_neg_hi;
        side_next.div0       = r3_div0;
        side_next.lo_pos     = r3_lo_pos;
        side_next.lo_neg     = r3_lo_neg;
        side_next.hi_pos     = r3_hi_pos;
        side_next.hi_neg     = r3_hi_neg;
    end

    iau_div_lane #(
        .QW(QW)
    ) u_div_lo (
        .clk (clk),
        .en  (adv),
        .num ({r3_mag_lo, {FRAC_BITS{1'b0}}}),
        .den (r3_den),
        .quo (quo_lo)
    );

    iau_div_lane #(
        .QW(QW)
    ) u_div_hi (
        .clk (clk),
        .en  (adv),
        .num ({r3_mag_hi, {FRAC_BITS{1'b0}}}),
        .den (r3_den),
        .quo (quo_hi)
    );

    // quotient sign restore, truncation toward zero falls out of the magnitudes
    always_comb
    begin
        q_lo_w = side_reg[QW-1].neg_lo ? -{1'b0, quo_lo} : {1'b0, quo_lo};
        q_hi_w = side_reg[QW-1].neg_hi ? -{1'b0, quo_hi} : {1'b0, quo_hi};
        q_lo_s = iau_pkg::sat32(66'(q_lo_w));
        q_hi_s = iau_pkg::sat32(66'(q_hi_w));
    end

    // final select and ordering
    always_comb
    begin
        dl = fq_lo;
        dh = fq_hi;
        if (f_side.mode == iau_pkg::MODE_DIV_S)
        begin
            if (f_side.div0)
            begin
                dl = f_side.lo_pos ? iau_pkg::S32_MAX :
                     (f_side.lo_neg ? iau_pkg::S32_MIN : 32'sd0);
                dh = f_side.hi_pos ? iau_pkg::S32_MAX :
                     (f_side.hi_neg ? iau_pkg::S32_MIN : 32'sd0);
                status_next = iau_pkg::ST_DIV0;
            end
            else
            begin
                status_next = fq_ovf ? iau_pkg::ST_OVF : iau_pkg::ST_OK;
            end
            r_min_next = (dl > dh) ? dh : dl;
            r_max_next = (dl > dh) ? dl : dh;
        end
        else
        begin
            r_min_next  = f_side.res_lo;
            r_max_next  = f_side.res_hi;
            status_next = f_side.res_ovf ? iau_pkg::ST_OVF : iau_pkg::ST_OK;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= 31'd1;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            vd_reg        <= '0;
            vf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tolerance_reg <= cfg_data;
            end
            if (adv)
            begin
                v0_reg        <= in_valid;
                v1_reg        <= v0_reg;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                vd_reg        <= {vd_reg[QW-2:0], v3_reg};
                vf_reg        <= vd_reg[QW-1];
                out_valid_reg <= vf_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_mode    <= iau_pkg::mode_t'(mode);
            r0_a_min   <= a_min;
            r0_a_max   <= a_max;
            r0_b_min   <= b_min;
            r0_b_max   <= b_max;
            r0_s       <= scalar;

            r1_mode    <= r0_mode;
            r1_als_lo  <= als_lo_s.val;
            r1_als_hi  <= als_hi_s.val;
            r1_als_ovf <= als_lo_s.ovf | als_hi_s.ovf;
            r1_hz      <= !(r0_a_min > 32'sd0) && !r0_a_max[31];
            r1_d_lo    <= 33'(r0_a_min) - 33'(r0_b_min);
            r1_d_hi    <= 33'(r0_a_max) - 33'(r0_b_max);
            r1_mag_lo  <= r0_a_min[31] ? 32'(-r0_a_min) : 32'(r0_a_min);
            r1_mag_hi  <= r0_a_max[31] ? 32'(-r0_a_max) : 32'(r0_a_max);
            r1_den     <= r0_s[31] ? 32'(-r0_s) : 32'(r0_s);
            r1_neg_lo  <= r0_a_min[31] ^ r0_s[31];
            r1_neg_hi  <= r0_a_max[31] ^ r0_s[31];
            r1_div0    <= (r0_s == 32'sd0);
            r1_lo_pos  <= (r0_a_min > 32'sd0);
            r1_lo_neg  <= r0_a_min[31];
            r1_hi_pos  <= (r0_a_max > 32'sd0);
            r1_hi_neg  <= r0_a_max[31];

            r2_mode    <= r1_mode;
            r2_als_lo  <= r1_als_lo;
            r2_als_hi  <= r1_als_hi;
            r2_als_ovf <= r1_als_ovf;
            r2_hz      <= r1_hz;
            r2_diff    <= (d_lo_x > tol_x) || (d_lo_x < -tol_x) ||
                          (d_hi_x > tol_x) || (d_hi_x < -tol_x);
            r2_mag_lo  <= r1_mag_lo;
            r2_mag_hi  <= r1_mag_hi;
            r2_den     <= r1_den;
            r2_neg_lo  <= r1_neg_lo;
            r2_neg_hi  <= r1_neg_hi;
            r2_div0    <= r1_div0;
            r2_lo_pos  <= r1_lo_pos;
            r2_lo_neg  <= r1_lo_neg;
            r2_hi_pos  <= r1_hi_pos;
            r2_hi_neg  <= r1_hi_neg;

            r3_mode    <= r2_mode;
            r3_als_lo  <= r2_als_lo;
            r3_als_hi  <= r2_als_hi;
            r3_als_ovf <= r2_als_ovf;
            r3_hz      <= r2_hz;
            r3_diff    <= r2_diff;
            r3_mag_lo  <= r2_mag_lo;
            r3_mag_hi  <= r2_mag_hi;
            r3_den     <= r2_den;
            r3_neg_lo  <= r2_neg_lo;
            r3_neg_hi  <= r2_neg_hi;
            r3_div0    <= r2_div0;
            r3_lo_pos  <= r2_lo_pos;
            r3_lo_neg  <= r2_lo_neg;
            r3_hi_pos  <= r2_hi_pos;
            r3_hi_neg  <= r2_hi_neg;

            side_reg[0] <= side_next;
            for (int i = 1; i < QW; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end

            f_side     <= side_reg[QW-1];
            fq_lo      <= q_lo_s.val;
            fq_hi      <= q_hi_s.val;
            fq_ovf     <= q_lo_s.ovf | q_hi_s.ovf;

            r_min_reg  <= r_min_next;
            r_max_reg  <= r_max_next;
            hz_reg     <= f_side.holds_zero;
            diff_reg   <= f_side.differs;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign r_min      = r_min_reg;
    assign r_max      = r_max_reg;
    assign holds_zero = hz_reg;
    assign differs    = diff_reg;
    assign status     = status_reg;

    // divide by zero always leaves an ordered interval of clamp values or zero
    a_div0_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == iau_pkg::ST_DIV0 |-> r_min <= r_max)
        else $error("divide by zero result not ordered");

    a_div0_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == iau_pkg::ST_DIV0 |->
            (r_min == iau_pkg::S32_MAX || r_min == iau_pkg::S32_MIN || r_min == 32'sd0))
        else $error("divide by zero end is not a clamp value");

    a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == iau_pkg::ST_OVF |->
            (r_min == iau_pkg::S32_MAX || r_min == iau_pkg::S32_MIN ||
             r_max == iau_pkg::S32_MAX || r_max == iau_pkg::S32_MIN))
        else $error("overflow flagged without a clamped end");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vd_reg))
        else $error("pipeline moved while stalled");

endmodule

// ===== rtl/core/iau_mul_unit.sv =====
// three-stage product unit: four products, pairwise min/max, final min/max with floor and clamp
`timescale 1ns / 1ps

module iau_mul_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a_min,
    input  logic signed [31:0] a_max,
    input  logic signed [31:0] b0,
    input  logic signed [31:0] b1,
    input  logic               scal,
    input  logic               swap,
    output logic signed [31:0] lo,
    output logic signed [31:0] hi,
    output logic               ovf
);

    logic signed [63:0] p_reg [4];
    logic               scal_reg;
    logic               swap_reg;
    logic signed [63:0] lo_a_reg, hi_a_reg, lo_b_reg, hi_b_reg;
    logic signed [63:0] lo_a_next, hi_a_next, lo_b_next, hi_b_next;
    logic signed [31:0] lo_reg, hi_reg;
    logic               ovf_reg;
    logic signed [63:0] mn, mx, mn_sh, mx_sh;
    iau_pkg::sat_t      sat_lo, sat_hi;

    always_comb
    begin
        if (scal_reg)
        begin
            // scalar product: p0 = a_min*s, p2 = a_max*s
            lo_a_next = swap_reg ? p_reg[2] : p_reg[0];
            hi_a_next = swap_reg ? p_reg[0] : p_reg[2];
            lo_b_next = lo_a_next;
            hi_b_next = hi_a_next;
        end
        else
        begin
            lo_a_next = (p_reg[1] < p_reg[0]) ? p_reg[1] : p_reg[0];
            hi_a_next = (p_reg[1] > p_reg[0]) ? p_reg[1] : p_reg[0];
            lo_b_next = (p_reg[3] < p_reg[2]) ? p_reg[3] : p_reg[2];
            hi_b_next = (p_reg[3] > p_reg[2]) ? p_reg[3] : p_reg[2];
        end
    end

    always_comb
    begin
        mn     = (lo_b_reg < lo_a_reg) ? lo_b_reg : lo_a_reg;
        mx     = (hi_b_reg > hi_a_reg) ? hi_b_reg : hi_a_reg;
        // arithmetic shift rounds toward minus infinity
        mn_sh  = mn >>> FRAC_BITS;
        mx_sh  = mx >>> FRAC_BITS;
        sat_lo = iau_pkg::sat32(66'(mn_sh));
        sat_hi = iau_pkg::sat32(66'(mx_sh));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= 64'(a_min) * 64'(b0);
            p_reg[1] <= 64'(a_min) * 64'(b1);
            p_reg[2] <= 64'(a_max) * 64'(b0);
            p_reg[3] <= 64'(a_max) * 64'(b1);
            scal_reg <= scal;
            swap_reg <= swap;
            lo_a_reg <= lo_a_next;
            hi_a_reg <= hi_a_next;
            lo_b_reg <= lo_b_next;
            hi_b_reg <= hi_b_next;
            lo_reg   <= sat_lo.val;
            hi_reg   <= sat_hi.val;
            ovf_reg  <= sat_lo.ovf | sat_hi.ovf;
        end
    end

    assign lo  = lo_reg;
    assign hi  = hi_reg;
    assign ovf = ovf_reg;

endmodule

// ===== rtl/core/iau_div_lane.sv =====
// pipelined restoring divider on magnitudes, one quotient bit per stage
`timescale 1ns / 1ps

module iau_div_lane #(
    parameter int QW = 48
) (
    input  logic          clk,
    input  logic          en,
    input  logic [QW-1:0] num,
    input  logic [31:0]   den,
    output logic [QW-1:0] quo
);

    logic [31:0]   rem_reg [QW];
    logic [QW-1:0] n_reg   [QW];
    logic [31:0]   d_reg   [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [31:0]   rem_in, d_in, rem_next;
        logic [QW-1:0] n_in, n_next;
        logic [32:0]   t;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign n_in   = num;
            assign d_in   = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign n_in   = n_reg[i-1];
            assign d_in   = d_reg[i-1];
        end

        // shift in the next dividend bit, quotient bits fill from the bottom
        always_comb
        begin
            t        = {rem_in, n_in[QW-1]};
            ge       = (t >= {1'b0, d_in});
            rem_next = ge ? 32'(t - {1'b0, d_in}) : t[31:0];
            n_next   = {n_in[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                n_reg[i]   <= n_next;
                d_reg[i]   <= d_in;
            end
        end
    end

    assign quo = n_reg[QW-1];

endmodule
